### src/lzbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lzbd_pkg;

	typedef enum logic [3:0] {
		PH_FLAG,
		PH_DGAM_DATA,
		PH_DGAM_CONT,
		PH_DIST_BYTE,
		PH_LEN1,
		PH_LEN2,
		PH_LGAM_DATA,
		PH_LGAM_CONT,
		PH_COPY,
		PH_AFTER,
		PH_LIT
	} phase_t;

	typedef enum logic [1:0] {
		FIN_NONE,
		FIN_DONE,
		FIN_ERROR
	} fin_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_READ,
		ST_RESP
	} ctrl_state_t;

	typedef struct packed {
		logic start;
		logic iter;
		logic copy_wr;
	} ctrl_cmd_t;

	typedef struct packed {
		logic copy_pend;
		logic stop;
	} dp_status_t;

	localparam logic [15:0] DIST_BIAS = 16'h0300;
	localparam logic [15:0] LONG_DIST = 16'h0d00;
	localparam logic [31:0] REUSE_GAMMA = 32'd2;

endpackage
`default_nettype wire

### src/lz_bitstream_decompressor.sv
// Each transaction on the input starts one decode step; its result is offered in the
// cycle after the step finishes. A step walks the decoded bit and byte phases in turn
// and adds a history memory read (ST_READ) for a copied byte.
// One step is in flight at a time; a new input is taken in the cycle after the result
// is taken.
// arst_n clears all decode state; the history memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module lz_bitstream_decompressor
	import lzbd_pkg::*;
#(
	parameter int HISTORY_DEPTH = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic             consumed,
	output logic             out_valid,
	output logic [7:0]       out_byte,
	output logic             done_res,
	output logic             error,
	output logic [31:0]      total_out
);
	ctrl_cmd_t  cmd;
	dp_status_t status;

	lzbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.status    (status),
		.cmd       (cmd)
	);

	lzbd_dp #(.DEPTH(HISTORY_DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_byte   (in_byte),
		.status    (status),
		.consumed  (consumed),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.done_res  (done_res),
		.error     (error),
		.total_out (total_out)
	);
endmodule
`default_nettype wire

### src/lzbd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module lzbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### src/lzbd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lzbd_ctrl
	import lzbd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            res_valid,
	input  wire logic       res_ready,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);
	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (status.copy_pend) begin
					state_d = ST_READ;
				end else begin
					cmd.iter = 1'b1;
					if (status.stop) begin
						state_d = ST_RESP;
					end
				end
			end
			ST_READ: begin
				cmd.copy_wr = 1'b1;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

### src/lzbd_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module lzbd_dp
	import lzbd_pkg::*;
#(
	parameter int DEPTH = 4096
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire ctrl_cmd_t  cmd,
	input  wire logic [7:0] in_byte,
	output dp_status_t      status,
	output logic            consumed,
	output logic            out_valid,
	output logic [7:0]      out_byte,
	output logic            done_res,
	output logic            error,
	output logic [31:0]     total_out
);
	localparam int AW = $clog2(DEPTH);
	localparam int DW = 18;

	logic [7:0]    inb_q;
	logic [15:0]   bb_q, bb_d;
	logic [31:0]   cnt_q, cnt_d;
	logic [AW-1:0] wp_q, wp_d;
	logic [15:0]   dist_q, dist_d;
	logic [31:0]   rem_q, rem_d;
	logic [31:0]   gam_q, gam_d;
	phase_t        ph_q, ph_d;
	fin_t          fin_q, fin_d;
	logic          took_q, took_d;
	logic          val_q, val_d;
	logic [7:0]    ob_q, ob_d;
	logic          we;
	logic [DW-1:0] diff;
	logic [AW-1:0] raddr;
	logic [7:0]    rdata;
	logic          stop;
	logic          bit_ok;
	logic          b;
	logic [15:0]   nb;
	logic [15:0]   dnew;
	logic [31:0]   len;
	logic [31:0]   clen;
	logic [31:0]   len2;

	always_comb begin
		diff = DW'(wp_q) - DW'(dist_q);
		if (diff[DW-1]) begin
			diff = diff + DW'(DEPTH);
		end
		raddr = diff[AW-1:0];
	end

	lzbd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_hist (
		.clk   (clk),
		.we    (we),
		.waddr (wp_q),
		.wdata (ob_d),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		bb_d = bb_q;
		cnt_d = cnt_q;
		wp_d = wp_q;
		dist_d = dist_q;
		rem_d = rem_q;
		gam_d = gam_q;
		ph_d = ph_q;
		fin_d = fin_q;
		took_d = took_q;
		val_d = val_q;
		ob_d = ob_q;
		we = 1'b0;
		stop = 1'b0;
		bit_ok = 1'b0;
		b = 1'b0;
		nb = {bb_q[14:0], 1'b0};
		dnew = 16'(inb_q) + {gam_q[7:0], 8'h00} + 16'd1 - DIST_BIAS;
		len = 32'd0;
		clen = 32'd0;
		len2 = {rem_q[30:0], 1'b0};
		if (nb[7:0] == 8'h00) begin
			if (!took_q) begin
				nb = {7'd0, inb_q, 1'b1};
				bit_ok = 1'b1;
			end
		end else begin
			bit_ok = 1'b1;
		end
		b = nb[8];
		if (cmd.start) begin
			took_d = 1'b0;
			val_d = 1'b0;
			ob_d = 8'h00;
		end else if (cmd.copy_wr) begin
			ob_d = rdata;
			val_d = 1'b1;
			we = 1'b1;
			rem_d = rem_q - 32'd1;
			if (rem_q == 32'd1) begin
				ph_d = PH_AFTER;
			end
		end else if (cmd.iter) begin
			if (fin_q != FIN_NONE) begin
				stop = 1'b1;
			end else if (ph_q == PH_LIT || ph_q == PH_DIST_BYTE) begin
				if (took_q) begin
					stop = 1'b1;
				end else begin
					took_d = 1'b1;
					if (ph_q == PH_LIT) begin
						ob_d = inb_q;
						val_d = 1'b1;
						we = 1'b1;
						ph_d = PH_FLAG;
						stop = 1'b1;
					end else if (dnew == 16'd0) begin
						fin_d = FIN_DONE;
						stop = 1'b1;
					end else begin
						dist_d = dnew;
						ph_d = PH_LEN1;
					end
				end
			end else if (!bit_ok) begin
				stop = 1'b1;
			end else begin
				bb_d = nb;
				if (bb_q[6:0] == 7'd0) begin
					took_d = 1'b1;
				end
				unique case (ph_q)
					PH_FLAG, PH_AFTER: begin
						if (b) begin
							ph_d = PH_LIT;
						end else begin
							gam_d = 32'd1;
							ph_d = PH_DGAM_DATA;
						end
					end
					PH_DGAM_DATA: begin
						gam_d = {gam_q[30:0], b};
						ph_d = PH_DGAM_CONT;
					end
					PH_DGAM_CONT: begin
						if (!b) begin
							ph_d = PH_DGAM_DATA;
						end else if (gam_q == REUSE_GAMMA) begin
							ph_d = PH_LEN1;
						end else begin
							ph_d = PH_DIST_BYTE;
						end
					end
					PH_LEN1: begin
						rem_d = {31'd0, b};
						ph_d = PH_LEN2;
					end
					PH_LEN2: begin
						len = {len2[31:1], b};
					end
					PH_LGAM_DATA: begin
						gam_d = {gam_q[30:0], b};
						ph_d = PH_LGAM_CONT;
					end
					PH_LGAM_CONT: begin
						if (!b) begin
							ph_d = PH_LGAM_DATA;
						end else begin
							len = gam_q + 32'd2;
						end
					end
					default: ph_d = PH_FLAG;
				endcase
				if ((ph_q == PH_LEN2 && len != 32'd0) || (ph_q == PH_LGAM_CONT && b)) begin
					clen = len + 32'd1 + ((dist_q > LONG_DIST) ? 32'd1 : 32'd0);
					if ({1'b0, dist_q} > 17'(DEPTH) || 32'(dist_q) > cnt_q) begin
						fin_d = FIN_ERROR;
						stop = 1'b1;
					end else begin
						rem_d = clen;
						ph_d = (clen != 32'd0) ? PH_COPY : PH_AFTER;
					end
				end else if (ph_q == PH_LEN2) begin
					gam_d = 32'd1;
					ph_d = PH_LGAM_DATA;
				end
			end
		end
		if (we) begin
			cnt_d = cnt_q + 32'd1;
			wp_d = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bb_q <= '0;
			cnt_q <= '0;
			wp_q <= '0;
			dist_q <= 16'd1;
			rem_q <= '0;
			gam_q <= 32'd1;
			ph_q <= PH_FLAG;
			fin_q <= FIN_NONE;
			took_q <= 1'b0;
			val_q <= 1'b0;
			ob_q <= '0;
		end else begin
			bb_q <= bb_d;
			cnt_q <= cnt_d;
			wp_q <= wp_d;
			dist_q <= dist_d;
			rem_q <= rem_d;
			gam_q <= gam_d;
			ph_q <= ph_d;
			fin_q <= fin_d;
			took_q <= took_d;
			val_q <= val_d;
			ob_q <= ob_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			inb_q <= in_byte;
		end
	end

	assign status.copy_pend = (ph_q == PH_COPY) && (fin_q == FIN_NONE);
	assign status.stop = stop;
	assign consumed = took_q;
	assign out_valid = val_q;
	assign out_byte = ob_q;
	assign done_res = (fin_q == FIN_DONE);
	assign error = (fin_q == FIN_ERROR);
	assign total_out = cnt_q;
endmodule
`default_nettype wire

### src/lzbd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module lzbd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic        out_valid,
	input wire logic [7:0]  out_byte,
	input wire logic        done_res,
	input wire logic        error
);
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn before it was taken");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && res_valid))
		else $error("input taken while a result is pending");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> out_byte == 8'h00)
		else $error("out_byte not zero without a byte");

	a_fin_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(done_res && error))
		else $error("done and error both set");

	a_no_byte_fin: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_valid |-> !done_res && !error)
		else $error("byte emitted after the stream ended");
endmodule

bind lz_bitstream_decompressor lzbd_checker u_lzbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.out_valid (out_valid),
	.out_byte  (out_byte),
	.done_res  (done_res),
	.error     (error)
);
`default_nettype wire

### tb/sv/tb_lz_bitstream_decompressor.sv
`timescale 1ns / 1ps
module tb_lz_bitstream_decompressor;
	import lzbd_pkg::*;

	localparam int DEPTH = 256;
	localparam int CYCLE_LIMIT = 1500000;

	typedef struct packed {
		logic        consumed;
		logic        ovalid;
		logic [7:0]  obyte;
		logic        done;
		logic        err;
		logic [31:0] total;
	} step_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [7:0]  in_byte = 8'h00;
	logic        res_ready = 1'b0;
	wire         in_ready;
	wire         res_valid;
	wire         consumed;
	wire         out_valid;
	wire  [7:0]  out_byte;
	wire         done_res;
	wire         error;
	wire  [31:0] total_out;

	lz_bitstream_decompressor #(.HISTORY_DEPTH(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
		.res_valid(res_valid), .res_ready(res_ready),
		.consumed(consumed), .out_valid(out_valid), .out_byte(out_byte),
		.done_res(done_res), .error(error), .total_out(total_out)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Decoder state as predicted.
	logic [15:0] pr_bits = 16'h0000;
	logic [7:0]  pr_hist [DEPTH];
	logic [31:0] pr_count = 32'd0;
	logic [15:0] pr_dist = 16'd1;
	logic [31:0] pr_remain = 32'd0;
	logic [31:0] pr_gamma = 32'd1;
	phase_t      pr_phase = PH_FLAG;
	fin_t        pr_fin = FIN_NONE;

	step_res_t   expected_out[$];
	int          fails = 0;
	int          checked = 0;
	int          bytes_seen = 0;
	int          cycles = 0;
	int          stall_pct = 0;

	// Compressed stream under construction and the encoder's view of it.
	logic [7:0]  comp[$];
	int          slot_idx = 0;
	int          slot_bits = 0;
	int          enc_count = 0;
	int          enc_dist = 1;
	int          feed_pos = 0;
	int          burst_left = 8;

	function automatic void store_out(logic [7:0] b);
		pr_hist[pr_count % DEPTH] = b;
		pr_count = pr_count + 32'd1;
	endfunction

	function automatic bit begin_copy(logic [31:0] len);
		len = len + 32'd1 + ((pr_dist > LONG_DIST) ? 32'd1 : 32'd0);
		if (32'(pr_dist) > DEPTH || 32'(pr_dist) > pr_count)
			return 1'b0;
		pr_remain = len;
		pr_phase = (len != 0) ? PH_COPY : PH_AFTER;
		return 1'b1;
	endfunction

	function automatic step_res_t decode_step(logic [7:0] b);
		step_res_t r;
		logic took, vld, stop, bv;
		logic [7:0] ob;
		logic [15:0] nb;
		logic [31:0] d, len;
		int g;
		took = 0; vld = 0; stop = 0; ob = 8'h00;
		for (g = 0; g < 64 && pr_fin == FIN_NONE && !vld && !stop; g++) begin
			if (pr_phase == PH_DIST_BYTE || pr_phase == PH_LIT) begin
				if (took) begin
					stop = 1;
				end else begin
					took = 1;
					if (pr_phase == PH_LIT) begin
						ob = b;
						vld = 1;
						store_out(ob);
						pr_phase = PH_FLAG;
					end else begin
						d = (32'(b) + pr_gamma * 32'h100 + 32'd1 - 32'(DIST_BIAS)) & 32'hffff;
						if (d == 0) begin
							pr_fin = FIN_DONE;
						end else begin
							pr_dist = d[15:0];
							pr_phase = PH_LEN1;
						end
					end
				end
			end else if (pr_phase == PH_COPY) begin
				ob = pr_hist[(pr_count - 32'(pr_dist)) % DEPTH];
				vld = 1;
				store_out(ob);
				pr_remain = pr_remain - 32'd1;
				if (pr_remain == 0)
					pr_phase = PH_AFTER;
			end else begin
				nb = {pr_bits[14:0], 1'b0};
				if (nb[7:0] == 8'h00) begin
					if (took) begin
						stop = 1;
					end else begin
						nb = {7'b0, b, 1'b1};
						took = 1;
					end
				end
				if (!stop) begin
					pr_bits = nb;
					bv = nb[8];
					case (pr_phase)
						PH_FLAG, PH_AFTER: begin
							if (bv) begin
								pr_phase = PH_LIT;
							end else begin
								pr_gamma = 32'd1;
								pr_phase = PH_DGAM_DATA;
							end
						end
						PH_DGAM_DATA: begin
							pr_gamma = pr_gamma * 2 + 32'(bv);
							pr_phase = PH_DGAM_CONT;
						end
						PH_DGAM_CONT: begin
							if (!bv)
								pr_phase = PH_DGAM_DATA;
							else
								pr_phase = (pr_gamma == REUSE_GAMMA) ? PH_LEN1 : PH_DIST_BYTE;
						end
						PH_LEN1: begin
							pr_remain = 32'(bv);
							pr_phase = PH_LEN2;
						end
						PH_LEN2: begin
							len = pr_remain * 2 + 32'(bv);
							if (len == 0) begin
								pr_gamma = 32'd1;
								pr_phase = PH_LGAM_DATA;
							end else if (!begin_copy(len)) begin
								pr_fin = FIN_ERROR;
							end
						end
						PH_LGAM_DATA: begin
							pr_gamma = pr_gamma * 2 + 32'(bv);
							pr_phase = PH_LGAM_CONT;
						end
						PH_LGAM_CONT: begin
							if (!bv)
								pr_phase = PH_LGAM_DATA;
							else if (!begin_copy(pr_gamma + 32'd2))
								pr_fin = FIN_ERROR;
						end
						default: pr_phase = PH_FLAG;
					endcase
				end
			end
		end
		r.consumed = took;
		r.ovalid = vld;
		r.obyte = vld ? ob : 8'h00;
		r.done = (pr_fin == FIN_DONE);
		r.err = (pr_fin == FIN_ERROR);
		r.total = pr_count;
		return r;
	endfunction

	// Encoder: control bits go into a reserved byte slot, bytes follow in order of need.
	function automatic void put_bit(bit b);
		if (slot_bits == 0) begin
			slot_idx = comp.size();
			comp.push_back(8'($urandom));
			slot_bits = 8;
		end
		comp[slot_idx][slot_bits - 1] = b;
		slot_bits--;
	endfunction

	function automatic void put_gamma(int unsigned g);
		int i, msb;
		msb = 0;
		for (i = 0; i < 32; i++)
			if (g[i])
				msb = i;
		for (i = msb - 1; i >= 0; i--) begin
			put_bit(g[i]);
			put_bit(i == 0);
		end
	endfunction

	function automatic void emit_literal(logic [7:0] v);
		put_bit(1'b1);
		comp.push_back(v);
		enc_count++;
	endfunction

	// n is the number of bytes copied; n >= 2, or 3 when d is above the long threshold.
	function automatic void emit_match(int d, int n, bit reuse);
		int extra, l;
		extra = (d > int'(LONG_DIST)) ? 1 : 0;
		l = n - 1 - extra;
		put_bit(1'b0);
		if (reuse && d == enc_dist) begin
			put_gamma(REUSE_GAMMA);
		end else begin
			put_gamma(((d - 1) >> 8) + 3);
			comp.push_back(8'((d - 1) & 255));
		end
		enc_dist = d;
		if (l <= 3) begin
			put_bit(l[1]);
			put_bit(l[0]);
		end else begin
			put_bit(1'b0);
			put_bit(1'b0);
			put_gamma(l - 2);
		end
		enc_count += n;
	endfunction

	task automatic send_item(input logic [7:0] b, output logic took);
		step_res_t r;
		r = decode_step(b);
		expected_out.push_back(r);
		in_valid <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (!in_ready);
		took = r.consumed;
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
	endtask

	task automatic feed_stream();
		int lim;
		logic took;
		lim = (slot_bits > 0) ? slot_idx : comp.size();
		while (feed_pos < lim && pr_fin == FIN_NONE) begin
			send_item(comp[feed_pos], took);
			if (took)
				feed_pos++;
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_out.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		emit_literal(8'h00);
		emit_literal(8'hff);
		emit_literal(8'ha5);
		emit_literal(8'h5a);
		emit_literal(8'h3c);
		emit_match(1, 2, 0);
		emit_match(1, 4, 1);
		emit_match(5, 3, 0);
		emit_match(2, 5, 0);
		emit_literal(8'h81);
		// Long run past the history depth so that the buffer index wraps.
		emit_match(1, 300, 1);
		emit_match(DEPTH, 4, 0);
		emit_match(DEPTH, 6, 1);
		emit_match(DEPTH - 1, 2, 0);
		emit_literal(8'h7e);
		feed_stream();
		wait_drained();
	endtask

	task automatic test_random_stream();
		int i, d, n, cap;
		bit reuse;
		for (i = 0; i < 200; i++) begin
			if ($urandom_range(0, 99) < 55) begin
				emit_literal(8'($urandom));
			end else begin
				cap = (enc_count < DEPTH) ? enc_count : DEPTH;
				reuse = ($urandom_range(0, 3) == 0) && (enc_dist <= cap);
				if (reuse)
					d = enc_dist;
				else if ($urandom_range(0, 3) != 0)
					d = $urandom_range(1, (cap < 64) ? cap : 64);
				else
					d = $urandom_range(1, cap);
				n = ($urandom_range(0, 9) < 7) ? $urandom_range(2, 4) : $urandom_range(5, 40);
				if (d > int'(LONG_DIST) && n < 3)
					n = 3;
				emit_match(d, n, reuse);
			end
			if (i % 40 == 39)
				feed_stream();
			if (i % 150 == 149)
				wait_drained();
		end
		feed_stream();
	endtask

	task automatic test_end_marker();
		logic took;
		int i;
		put_bit(1'b0);
		put_gamma(258);
		comp.push_back(8'hff);
		slot_bits = 0;
		feed_stream();
		// Further transactions after the end must be ignored by the decoder.
		for (i = 0; i < 20; i++)
			send_item(8'($urandom), took);
	endtask

	function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
		if (exp !== act) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
			fails++;
		end
	endfunction

	always @(posedge clk) begin
		step_res_t e;
		cycles <= cycles + 1;
		if (cycles % 256 == 0)
			stall_pct <= ($urandom_range(0, 3) < 2) ? 0 : $urandom_range(20, 80);
		res_ready <= ($urandom_range(0, 99) >= stall_pct);
		if (res_valid && res_ready) begin
			if (expected_out.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0h", $time,
					{consumed, out_valid, out_byte, done_res, error, total_out});
				fails++;
			end else begin
				e = expected_out.pop_front();
				check_field("consumed", e.consumed, consumed);
				check_field("out_valid", e.ovalid, out_valid);
				check_field("out_byte", e.obyte, out_byte);
				check_field("done_res", e.done, done_res);
				check_field("error", e.err, error);
				check_field("total_out", e.total, total_out);
				checked++;
				if (e.ovalid)
					bytes_seen++;
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_stream();
		test_end_marker();
		wait_drained();
		repeat (50) @(posedge clk);
		if (expected_out.size() != 0)
			fails++;
		$display("Checked %0d decode steps carrying %0d output bytes from a %0d-byte stream.",
			checked, bytes_seen, comp.size());
		$display("Covered literals, reused and full-depth distances, history wrap and the end marker.");
		if (fails == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
